// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on the rising clock edge, disabled while in reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// Condition that must never be true on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

// ===== design/asfl_pkg.sv =====
package asfl_pkg;

  // Physical depth of the link memory.
  localparam int MAX_SLOTS = 1024;
  // Widths of a slot index and of a slot count.
  localparam int IDX_W = 10;
  localparam int CNT_W = IDX_W + 1;
  // Largest usable count, bounded by both the depth and the index width.
  localparam int N_LIMIT = (MAX_SLOTS < (1 << IDX_W)) ? MAX_SLOTS : (1 << IDX_W);
  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = CNT_W'(1024);

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_t;

endpackage

// ===== design/array_slot_free_list_core.sv =====
// Channel   Handshake               Payload
// in        in_valid / in_ready     in_mode, in_slot_index
// out       out_valid / out_ready   out_granted_slot, out_full_res, out_in_use, out_bad_index
// cfg       cfg_wr_en (no wait)     cfg_wr_data -> slot_count
//
// Allocate and release each make one access to the single-port link memory and
// then hand the word to the output register. Clear sweeps the entries and query
// walks the list, one link memory access per cycle.
// After reset a clearing pass rebuilds the list before the first
// input word is accepted; configuration writes are still taken during it.
// A stalled output holds the finishing state, so no link update is repeated.

`include "assert_macros.svh"

module array_slot_free_list_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_mode,
  input  logic [asfl_pkg::IDX_W-1:0]     in_slot_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [asfl_pkg::IDX_W-1:0]     out_granted_slot,
  output logic                           out_full_res,
  output logic                           out_in_use,
  output logic                           out_bad_index,
  input  logic                           cfg_wr_en,
  input  logic [asfl_pkg::CNT_W-1:0]     cfg_wr_data
);

  localparam int IDX_W = asfl_pkg::IDX_W;
  localparam int CNT_W = asfl_pkg::CNT_W;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_ALLOC = 5'b00100,
    ST_QWALK = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   slot_count_r, slot_count_nxt;
  // The header link (entry 0) lives in a register so allocate and release
  // need only one memory access each.
  logic [IDX_W-1:0]   head_r, head_nxt;
  // Clear pointer, and current list entry during a query walk.
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [IDX_W-1:0]   last_r, last_nxt;
  logic               boot_r, boot_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   steps_r, steps_nxt;
  logic               res_full_r, res_full_nxt;
  logic               res_bad_r, res_bad_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]   out_granted_r, out_granted_nxt;
  logic               out_full_r, out_full_nxt;
  logic               out_in_use_r, out_in_use_nxt;
  logic               out_bad_r, out_bad_nxt;

  // Link memory: one write or one read per cycle, read data registered.
  logic [IDX_W-1:0]   link_mem [asfl_pkg::MAX_SLOTS];
  logic [IDX_W-1:0]   rdata_r;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_wdata, mem_raddr;

  logic [CNT_W-1:0]   n_eff;
  logic               out_free, accept, rel_bad, q_end, q_hit;
  asfl_pkg::mode_t    mode;

  // Effective count: slot_count saturated into the usable range.
  always_comb begin
    if (slot_count_r < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (slot_count_r > CNT_W'(asfl_pkg::N_LIMIT)) begin
      n_eff = CNT_W'(asfl_pkg::N_LIMIT);
    end else begin
      n_eff = slot_count_r;
    end
  end

  assign mode     = asfl_pkg::mode_t'(in_mode);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign rel_bad  = (in_slot_index == '0) || ({1'b0, in_slot_index} >= n_eff);
  // The walk stops as used on the end of the list or when the step bound runs out.
  assign q_end    = (ptr_r == '0) || (steps_r >= n_eff);
  assign q_hit    = (ptr_r == idx_r);

  always_comb begin
    state_nxt       = state_r;
    slot_count_nxt  = slot_count_r;
    head_nxt        = head_r;
    ptr_nxt         = ptr_r;
    last_nxt        = last_r;
    boot_nxt        = boot_r;
    idx_nxt         = idx_r;
    steps_nxt       = steps_r;
    res_full_nxt    = res_full_r;
    res_bad_nxt     = res_bad_r;
    out_valid_nxt   = out_valid_r;
    out_granted_nxt = out_granted_r;
    out_full_nxt    = out_full_r;
    out_in_use_nxt  = out_in_use_r;
    out_bad_nxt     = out_bad_r;
    mem_we          = 1'b0;
    mem_waddr       = ptr_r;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = head_r;

    if (cfg_wr_en) begin
      slot_count_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            asfl_pkg::MODE_CLEAR: begin
              // Entry 0 links to 1; the sweep rewrites entries 1 to n-1.
              head_nxt  = IDX_W'(1);
              ptr_nxt   = IDX_W'(1);
              last_nxt  = IDX_W'(n_eff - CNT_W'(1));
              boot_nxt  = 1'b0;
              state_nxt = ST_CLEAR;
            end
            asfl_pkg::MODE_ALLOC: begin
              if (head_r == '0) begin
                res_full_nxt = 1'b1;
                res_bad_nxt  = 1'b0;
                state_nxt    = ST_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                state_nxt = ST_ALLOC;
              end
            end
            asfl_pkg::MODE_RELEASE: begin
              res_full_nxt = 1'b0;
              res_bad_nxt  = rel_bad;
              if (!rel_bad) begin
                mem_we    = 1'b1;
                mem_waddr = in_slot_index;
                mem_wdata = head_r;
                head_nxt  = in_slot_index;
              end
              state_nxt = ST_DONE;
            end
            asfl_pkg::MODE_QUERY: begin
              ptr_nxt   = head_r;
              idx_nxt   = in_slot_index;
              steps_nxt = '0;
              mem_re    = 1'b1;
              mem_raddr = head_r;
              state_nxt = ST_QWALK;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = (ptr_r == last_r) ? '0 : ptr_r + IDX_W'(1);
        ptr_nxt   = ptr_r + IDX_W'(1);
        if (ptr_r == last_r) begin
          if (boot_r) begin
            boot_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            res_full_nxt = 1'b0;
            res_bad_nxt  = 1'b0;
            state_nxt    = ST_DONE;
          end
        end
      end
      ST_ALLOC: begin
        if (out_free) begin
          head_nxt        = rdata_r;
          out_valid_nxt   = 1'b1;
          out_granted_nxt = head_r;
          out_full_nxt    = 1'b0;
          out_in_use_nxt  = 1'b0;
          out_bad_nxt     = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      ST_QWALK: begin
        if (q_end || q_hit) begin
          if (out_free) begin
            out_valid_nxt   = 1'b1;
            out_granted_nxt = '0;
            out_full_nxt    = 1'b0;
            out_in_use_nxt  = q_end;
            out_bad_nxt     = 1'b0;
            state_nxt       = ST_IDLE;
          end
        end else begin
          // rdata_r holds the link of the current entry: follow it.
          ptr_nxt   = rdata_r;
          mem_re    = 1'b1;
          mem_raddr = rdata_r;
          steps_nxt = steps_r + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = '0;
          out_full_nxt    = res_full_r;
          out_in_use_nxt  = 1'b0;
          out_bad_nxt     = res_bad_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= link_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // Reset starts the clearing pass over the full list.
      state_r      <= ST_CLEAR;
      slot_count_r <= asfl_pkg::SLOT_COUNT_RST;
      head_r       <= IDX_W'(1);
      ptr_r        <= IDX_W'(1);
      last_r       <= IDX_W'(asfl_pkg::N_LIMIT - 1);
      boot_r       <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_count_r <= slot_count_nxt;
      head_r       <= head_nxt;
      ptr_r        <= ptr_nxt;
      last_r       <= last_nxt;
      boot_r       <= boot_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    steps_r       <= steps_nxt;
    res_full_r    <= res_full_nxt;
    res_bad_r     <= res_bad_nxt;
    out_granted_r <= out_granted_nxt;
    out_full_r    <= out_full_nxt;
    out_in_use_r  <= out_in_use_nxt;
    out_bad_r     <= out_bad_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_granted_r;
  assign out_full_res     = out_full_r;
  assign out_in_use       = out_in_use_r;
  assign out_bad_index    = out_bad_r;

  // The walk never runs past the effective count.
  `ASSERT_NEVER(a_walk_bound, clk, rst_n,
    (state_r == ST_QWALK) && (steps_r > n_eff))
  // A valid release makes the released slot the new head.
  `ASSERT_CLK(a_release_head, clk, rst_n,
    (accept && (mode == asfl_pkg::MODE_RELEASE) && !rel_bad)
      |=> (head_r == $past(in_slot_index)))
  // A finishing allocate hands out the old head.
  `ASSERT_CLK(a_alloc_grant, clk, rst_n,
    ((state_r == ST_ALLOC) && out_free)
      |=> (out_valid && (out_granted_slot == $past(head_r))))

endmodule
